// File: hdl/multicolor_turmite_stepper_assert.svh
// Assertion macros used by the turmite stepper RTL (included by tms_core).
// Each macro needs a signal named clk and a signal named rst in the including module.
`ifndef MULTICOLOR_TURMITE_STEPPER_ASSERT_SVH
`define MULTICOLOR_TURMITE_STEPPER_ASSERT_SVH

// Same-cycle implication.
`define TMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define TMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tms_pkg.sv
// Package for the multicolor turmite stepper: grid geometry, field widths,
// request/response structs, codes and state machine type. No dependencies.
`default_nettype none

package tms_pkg;

  localparam int unsigned GRID_SIDE  = 1024;
  localparam int unsigned MAX_COLORS = 64;

  // Usable side is rounded down to a multiple of four.
  localparam int unsigned SIDE    = (GRID_SIDE / 4) * 4;
  localparam int unsigned HALF    = SIDE / 2;
  localparam int unsigned COORD_W = $clog2(SIDE);
  localparam int unsigned ADDR_W  = 2 * COORD_W;
  localparam int unsigned CELL_W  = $clog2(MAX_COLORS);

  localparam logic [COORD_W:0]   SIDE_EXT = SIDE[COORD_W:0];
  localparam logic [COORD_W-1:0] HALF_POS = HALF[COORD_W-1:0];

  localparam int unsigned XY_W     = 10;
  localparam int unsigned COLOR_W  = 6;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned TURN_W   = 64;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned CFG_IW   = 2;

  localparam logic [COUNT_W-1:0] MAX_COUNT = MAX_COLORS[COUNT_W-1:0];

  localparam logic [TURN_W-1:0]  TURN_PATTERN_RST = TURN_W'(1);
  localparam logic [COUNT_W-1:0] COLOR_COUNT_RST  = COUNT_W'(2);
  localparam logic [STEP_W-1:0]  STEP_LIMIT_RST   = STEP_W'(100000000);

  typedef enum logic [1:0] {
    REQ_STEP    = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RESTART = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    RUN_ACTIVE = 2'd0,
    HALT_EDGE  = 2'd1,
    HALT_LIMIT = 2'd2
  } halt_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_TURN_PATTERN = 2'd0,
    REG_COLOR_COUNT  = 2'd1,
    REG_STEP_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [XY_W-1:0] cell_x;
    logic [XY_W-1:0] cell_y;
  } req_t;

  typedef struct packed {
    logic [XY_W-1:0]    ant_x;
    logic [XY_W-1:0]    ant_y;
    logic [COLOR_W-1:0] cell_color;
    logic [1:0]         run_status;
    logic [STEP_W-1:0]  steps_done;
  } rsp_t;

  typedef struct packed {
    logic [TURN_W-1:0]  turn_pattern;
    logic [COUNT_W-1:0] color_count;
    logic [STEP_W-1:0]  step_limit;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

endpackage

`default_nettype wire

// File: hdl/tms_grid_ram.sv
// Simple dual-port grid RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tms_grid_ram #(
  parameter int unsigned DATA_W = 6,
  parameter int unsigned ADDR_W = 20
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/tms_cfg.sv
// Configuration registers of the turmite stepper (turn pattern, color count,
// step limit). Depends on tms_pkg.
`default_nettype none

module tms_cfg
  import tms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  output      cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_pattern <= TURN_PATTERN_RST;
      cfg.color_count  <= COLOR_COUNT_RST;
      cfg.step_limit   <= STEP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TURN_PATTERN: cfg.turn_pattern <= cfg_wdata[TURN_W-1:0];
        REG_COLOR_COUNT:  cfg.color_count  <= cfg_wdata[COUNT_W-1:0];
        REG_STEP_LIMIT:   cfg.step_limit   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/tms_core.sv
// Turmite sequencer: ant state, read-modify-write of the grid RAM, clearing
// sweep and the response register. Depends on tms_pkg and the assert header.
`default_nettype none
`include "multicolor_turmite_stepper_assert.svh"

module tms_core
  import tms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire req_t              req,
  input  wire cfg_t              cfg,
  input  wire logic [CELL_W-1:0] mem_rdata,
  output      logic              busy,
  output      logic              done,
  output      rsp_t              rsp,
  output      mem_cmd_t          mem
);

  state_t state, state_next;

  logic [COORD_W-1:0] ant_col, ant_row;
  logic               dir_neg, vphase;
  logic [STEP_W-1:0]  step_cnt;
  halt_t              halt;
  logic [ADDR_W-1:0]  clear_addr;
  logic [1:0]         cur_req;
  logic               rd_ok;

  logic               accept;
  logic               do_step;
  logic               req_in_grid;

  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] inc;
  logic [CELL_W-1:0]  color_next;
  logic               flip;
  logic [COORD_W-1:0] pos;
  logic [COORD_W:0]   moved;
  logic               off_grid;
  logic [COORD_W-1:0] ant_col_next, ant_row_next;
  logic               dir_neg_next, vphase_next;
  logic [STEP_W-1:0]  step_cnt_next;
  halt_t              halt_next;
  rsp_t               rsp_next;

  assign accept  = start && (state == ST_IDLE);
  assign do_step = (cur_req == REQ_STEP) && (halt == RUN_ACTIVE);
  assign req_in_grid = (32'(req.cell_x) < SIDE) && (32'(req.cell_y) < SIDE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (&clear_addr) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_next = (req.req_type == REQ_RESTART) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  // RAM control
  always_comb begin
    busy      = (state != ST_IDLE);
    mem.we    = 1'b0;
    mem.waddr = {ant_row, ant_col};
    mem.wdata = color_next;
    mem.raddr = {ant_row, ant_col};
    unique case (state)
      ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clear_addr;
        mem.wdata = '0;
      end
      ST_IDLE: begin
        if (req.req_type == REQ_READ) begin
          mem.raddr = {COORD_W'(req.cell_y), COORD_W'(req.cell_x)};
        end
      end
      ST_EXEC: mem.we = do_step;
      default: ;
    endcase
  end

  // One half-step on the color just read
  always_comb begin
    count_eff  = (cfg.color_count > MAX_COUNT) ? MAX_COUNT : cfg.color_count;
    inc        = COUNT_W'(mem_rdata) + COUNT_W'(1);
    color_next = (inc < count_eff) ? CELL_W'(inc) : '0;
    flip       = vphase ^ cfg.turn_pattern[mem_rdata];

    ant_col_next  = ant_col;
    ant_row_next  = ant_row;
    dir_neg_next  = dir_neg ^ flip;
    vphase_next   = vphase;
    step_cnt_next = step_cnt + STEP_W'(1);
    halt_next     = halt;

    pos = vphase ? ant_row : ant_col;
    if (dir_neg_next) begin
      off_grid = (pos == '0);
      moved    = {1'b0, pos} - (COORD_W+1)'(1);
    end else begin
      moved    = {1'b0, pos} + (COORD_W+1)'(1);
      off_grid = (moved >= SIDE_EXT);
    end

    if (off_grid) begin
      halt_next = HALT_EDGE;
    end else begin
      if (vphase) ant_row_next = moved[COORD_W-1:0];
      else        ant_col_next = moved[COORD_W-1:0];
      vphase_next = ~vphase;
      if (step_cnt_next >= cfg.step_limit) halt_next = HALT_LIMIT;
    end

    rsp_next.cell_color = ((cur_req == REQ_READ) && rd_ok) ? COLOR_W'(mem_rdata) : '0;
    if (do_step) begin
      rsp_next.ant_x      = XY_W'(ant_col_next);
      rsp_next.ant_y      = XY_W'(ant_row_next);
      rsp_next.run_status = halt_next;
      rsp_next.steps_done = step_cnt_next;
    end else begin
      rsp_next.ant_x      = XY_W'(ant_col);
      rsp_next.ant_y      = XY_W'(ant_row);
      rsp_next.run_status = halt;
      rsp_next.steps_done = step_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      ant_col    <= HALF_POS;
      ant_row    <= HALF_POS;
      dir_neg    <= 1'b0;
      vphase     <= 1'b0;
      step_cnt   <= '0;
      halt       <= RUN_ACTIVE;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      // wraps back to zero at the end of the sweep, ready for the next one
      if (state == ST_CLEAR) clear_addr <= clear_addr + ADDR_W'(1);
      if (accept && (req.req_type == REQ_RESTART)) begin
        ant_col  <= HALF_POS;
        ant_row  <= HALF_POS;
        dir_neg  <= 1'b0;
        vphase   <= 1'b0;
        step_cnt <= '0;
        halt     <= RUN_ACTIVE;
        done     <= 1'b1;
      end
      if ((state == ST_EXEC) && do_step) begin
        ant_col  <= ant_col_next;
        ant_row  <= ant_row_next;
        dir_neg  <= dir_neg_next;
        vphase   <= vphase_next;
        step_cnt <= step_cnt_next;
        halt     <= halt_next;
      end
      if (state == ST_EXEC) done <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_req <= req.req_type;
      rd_ok   <= req_in_grid;
    end
    if (accept && (req.req_type == REQ_RESTART)) begin
      rsp.ant_x      <= XY_W'(HALF_POS);
      rsp.ant_y      <= XY_W'(HALF_POS);
      rsp.cell_color <= '0;
      rsp.run_status <= RUN_ACTIVE;
      rsp.steps_done <= '0;
    end else if (state == ST_EXEC) begin
      rsp <= rsp_next;
    end
  end

  `TMS_ASSERT_NEXT(a_exec_done, state == ST_EXEC, done, "no response after execute")
  `TMS_ASSERT_NOW(a_idle_no_wr, state == ST_IDLE, !mem.we, "grid write while idle")
  `TMS_ASSERT_NOW(a_clear_wr, state == ST_CLEAR, mem.we && !busy == 1'b0, "clear sweep stalled")
  `TMS_ASSERT_NEXT(a_halt_hold, (state == ST_EXEC) && (halt != RUN_ACTIVE), $stable(step_cnt), "halted ant counted a step")
  `TMS_ASSERT_NOW(a_in_grid, 1'b1, ({1'b0, ant_col} < SIDE_EXT) && ({1'b0, ant_row} < SIDE_EXT), "ant outside grid")

endmodule

`default_nettype wire

// File: hdl/multicolor_turmite_stepper.sv
// Top level of the multicolor turmite stepper: config registers, sequencer
// and grid RAM. Depends on tms_pkg, tms_cfg, tms_core and tms_grid_ram.
//
//   channel   handshake          payload
//   request   start / busy       req (req_type, cell_x, cell_y)
//   response  done (1 cycle)     rsp (ant_x, ant_y, cell_color, run_status, steps_done)
//   config    cfg_we             cfg_index, cfg_wdata
//
// Step and read each take one grid RAM read, then an active step updates and
// writes back that cell; the response shows the cycle after, and the next
// request may be taken in that same cycle.
// Restart answers the next cycle, then busy stays high while the RAM is swept,
// one cell per cycle over all 2**20 cells. Reset starts the same sweep.
// Responses cannot be stalled; config writes are taken on any cycle.
`default_nettype none

module multicolor_turmite_stepper
  import tms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire req_t              req,
  output      logic              busy,
  output      logic              done,
  output      rsp_t              rsp,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t              cfg;
  mem_cmd_t          mem;
  logic [CELL_W-1:0] mem_rdata;

  tms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .cfg       (cfg),
    .mem_rdata (mem_rdata),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .mem       (mem)
  );

  tms_grid_ram #(
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
